[hw/rtl/ps2mq_pkg.sv]
// ============================================================================
// ps2mq_pkg
// Shared types and constants of the PS/2 mouse packet event queue.
// ============================================================================
`default_nettype none

package ps2mq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int COORD_BITS  = 12;
	localparam int CMDQ_DEPTH  = 2;
	localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
	localparam int PADDR_W     = 4;

	localparam logic [7:0] SYNC_BIT  = 8'h08;
	localparam logic [7:0] OVF_BITS  = 8'hC0;

	localparam logic [COORD_BITS-1:0] POS_X_RST = COORD_BITS'(200);
	localparam logic [COORD_BITS-1:0] POS_Y_RST = COORD_BITS'(150);

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_MOVE,
		KIND_DOWN,
		KIND_UP
	} ev_kind_t;

	typedef enum logic [1:0] {
		OP_SKIP,
		OP_BYTE,
		OP_TAKE
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		ev_kind_t              kind;
		logic [2:0]            button;
		logic [2:0]            buttons;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} slot_t;

	typedef struct packed {
		logic                  enable;
		logic [COORD_BITS-1:0] width;
		logic [COORD_BITS-1:0] height;
	} cfg_t;

	typedef struct packed {
		logic                  wr_width;
		logic                  wr_height;
		logic [COORD_BITS-1:0] value;
	} cfg_wr_t;

	typedef struct packed {
		slot_t                 ev;
		logic [COORD_BITS-1:0] cur_x;
		logic [COORD_BITS-1:0] cur_y;
		logic [2:0]            cur_buttons;
		logic                  has_event;
	} result_t;

endpackage

`default_nettype wire

[hw/rtl/ps2_mouse_packet_event_queue.sv]
// ============================================================================
// ps2_mouse_packet_event_queue
// PS/2 mouse packet decoder with a cursor and a ring of input events.
// ============================================================================
`default_nettype none

// Each input transaction is either a device byte (func 0) or a request to take
// the oldest queued event (func 1); every input transaction yields exactly one
// output transaction. A two-entry command queue decouples the input channel from
// the sequencer, so new transactions are accepted while a result waits on a
// stalled output. The sequencer takes a queued command once it is idle and its
// output is free. Skipped bytes and the first two bytes of a packet post their
// result from ST_IDLE; a take from a nonempty ring reads the event in ST_TAKE,
// as the event ring is a memory with a registered read port. The third byte of
// a valid packet updates the cursor and buttons, runs four event steps (a move,
// then left, right and middle button changes), each of which may write the
// ring's single write port, and posts the result in ST_DONE. The ring has 32
// slots and holds at most 31 events; a move right after a queued move updates
// that entry in place, and an event that finds the ring full is dropped.
// Registers at byte addresses 0 (enable), 4 (width) and 8 (height) are to be
// written through the APB port only while the block is idle; the block itself
// does not enforce this. Writing a nonzero bound pulls the cursor inside it.
// Bytes received while disabled are ignored and a partly gathered packet is kept.

module ps2_mouse_packet_event_queue (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Input channel
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               func,
	input  wire logic [7:0]                         data,
	// Output channel
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [1:0]                              ev_kind,
	output logic [2:0]                              ev_button,
	output logic [2:0]                              ev_buttons,
	output logic [ps2mq_pkg::COORD_BITS-1:0]        ev_x,
	output logic [ps2mq_pkg::COORD_BITS-1:0]        ev_y,
	output logic [ps2mq_pkg::COORD_BITS-1:0]        cur_x,
	output logic [ps2mq_pkg::COORD_BITS-1:0]        cur_y,
	output logic [2:0]                              cur_buttons,
	output logic                                    has_event,
	// Configuration port
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [ps2mq_pkg::PADDR_W-1:0]      paddr,
	input  wire logic [31:0]                        pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready
);

	typedef enum logic [ps2mq_pkg::PADDR_W-3:0] {
		REG_ENABLE,
		REG_WIDTH,
		REG_HEIGHT
	} reg_idx_t;

	localparam int CW = ps2mq_pkg::COORD_BITS;

	logic                   enable_q;
	logic [CW-1:0]          width_q;
	logic [CW-1:0]          height_q;
	logic                   wr;
	reg_idx_t               reg_idx;
	ps2mq_pkg::cfg_t        cfg;
	ps2mq_pkg::cfg_wr_t     cfg_wr;
	logic                   cmd_valid;
	ps2mq_pkg::cmd_t        cmd;
	logic                   cmd_pop;
	ps2mq_pkg::result_t     res;

	// The register file answers in the access cycle, so the port never waits.
	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[ps2mq_pkg::PADDR_W-1:2]);

	always_comb begin
		case (reg_idx)
			REG_ENABLE: prdata = {31'd0, enable_q};
			REG_WIDTH:  prdata = {{(32-CW){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(32-CW){1'b0}}, height_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			width_q  <= '0;
			height_q <= '0;
		end else if (wr) begin
			case (reg_idx)
				REG_ENABLE: enable_q <= pwdata[0];
				REG_WIDTH:  width_q  <= pwdata[CW-1:0];
				REG_HEIGHT: height_q <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.enable = enable_q;
	assign cfg.width  = width_q;
	assign cfg.height = height_q;

	// Bound writes are forwarded so the sequencer can pull the cursor inside.
	assign cfg_wr.wr_width  = wr && (reg_idx == REG_WIDTH);
	assign cfg_wr.wr_height = wr && (reg_idx == REG_HEIGHT);
	assign cfg_wr.value     = pwdata[CW-1:0];

	ps2mq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.data      (data),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	ps2mq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.cfg       (cfg),
		.cfg_wr    (cfg_wr),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign ev_kind     = res.ev.kind;
	assign ev_button   = res.ev.button;
	assign ev_buttons  = res.ev.buttons;
	assign ev_x        = res.ev.x;
	assign ev_y        = res.ev.y;
	assign cur_x       = res.cur_x;
	assign cur_y       = res.cur_y;
	assign cur_buttons = res.cur_buttons;
	assign has_event   = res.has_event;

endmodule

`default_nettype wire

[hw/rtl/ps2mq_front.sv]
// ============================================================================
// ps2mq_front
// Accepts input transactions, classifies them and holds them in a short queue.
// ============================================================================
`default_nettype none

module ps2mq_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               func,
	input  wire logic [7:0]         data,
	input  wire ps2mq_pkg::cfg_t    cfg,
	output logic                    cmd_valid,
	output ps2mq_pkg::cmd_t         cmd,
	input  wire logic               cmd_pop
);

	ps2mq_pkg::cmd_t                    fifo_q [ps2mq_pkg::CMDQ_DEPTH];
	logic [ps2mq_pkg::CMDQ_PTR_W-1:0]   wr_ptr_q;
	logic [ps2mq_pkg::CMDQ_PTR_W-1:0]   rd_ptr_q;
	logic [ps2mq_pkg::CMDQ_PTR_W:0]     cnt_q;
	logic                               push;
	ps2mq_pkg::cmd_t                    cmd_in;

	assign in_stall  = (cnt_q == (ps2mq_pkg::CMDQ_PTR_W+1)'(ps2mq_pkg::CMDQ_DEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];

	// Device bytes that arrive while disabled are marked so the back end skips them.
	always_comb begin
		cmd_in.data = data;
		if (func) begin
			cmd_in.op = ps2mq_pkg::OP_TAKE;
		end else if (cfg.enable) begin
			cmd_in.op = ps2mq_pkg::OP_BYTE;
		end else begin
			cmd_in.op = ps2mq_pkg::OP_SKIP;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == ps2mq_pkg::CMDQ_PTR_W'(ps2mq_pkg::CMDQ_DEPTH-1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == ps2mq_pkg::CMDQ_PTR_W'(ps2mq_pkg::CMDQ_DEPTH-1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && cmd_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cnt_q != '0)
		else $error("command popped from an empty queue");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (ps2mq_pkg::CMDQ_PTR_W+1)'(ps2mq_pkg::CMDQ_DEPTH))
		else $error("command queue count out of range");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_stall && !cmd_pop) |=> $stable(cnt_q))
		else $error("full queue changed without a pop");

endmodule

`default_nettype wire

[hw/rtl/ps2mq_back.sv]
// ============================================================================
// ps2mq_back
// Sequencer that decodes packets, moves the cursor and runs the event ring.
// ============================================================================
`default_nettype none

module ps2mq_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	input  wire ps2mq_pkg::cmd_t     cmd,
	output logic                     cmd_pop,
	input  wire ps2mq_pkg::cfg_t     cfg,
	input  wire ps2mq_pkg::cfg_wr_t  cfg_wr,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output ps2mq_pkg::result_t       res
);

	localparam int CW    = ps2mq_pkg::COORD_BITS;
	localparam int PW    = ps2mq_pkg::PTR_W;
	localparam int SUM_W = CW + 2;
	localparam logic [1:0] LAST_STEP = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TAKE,
		ST_PUSH,
		ST_DONE
	} state_t;

	state_t                 state_q;
	logic [1:0]             step_q;
	logic [1:0]             byte_idx_q;
	logic [7:0]             first_q;
	logic [7:0]             second_q;
	logic [CW-1:0]          pos_x_q;
	logic [CW-1:0]          pos_y_q;
	logic [2:0]             btn_q;
	logic [2:0]             prev_btn_q;
	logic                   move_req_q;
	logic [PW-1:0]          head_q;
	logic [PW-1:0]          tail_q;
	logic                   last_move_q;
	logic                   out_valid_q;
	ps2mq_pkg::result_t     res_q;

	ps2mq_pkg::slot_t       mem [ps2mq_pkg::QUEUE_DEPTH];
	ps2mq_pkg::slot_t       rd_q;

	logic                   start;
	logic                   rd_en;
	logic                   ring_empty;
	logic [PW-1:0]          next_head;
	logic [PW-1:0]          prev_head;
	logic [PW-1:0]          next_tail;
	logic                   full;
	logic                   push_req;
	ps2mq_pkg::ev_kind_t    push_kind;
	logic [2:0]             push_btn;
	logic [2:0]             bit_sel;
	logic                   merge;
	logic                   mem_we;
	logic [PW-1:0]          mem_wa;
	ps2mq_pkg::slot_t       mem_wd;
	logic signed [8:0]      dx;
	logic signed [8:0]      dy;
	logic signed [SUM_W-1:0] sum_x;
	logic signed [SUM_W-1:0] sum_y;
	logic [CW-1:0]          new_x;
	logic [CW-1:0]          new_y;
	logic                   delta_nz;

	function automatic logic [CW-1:0] clamp_axis(input logic signed [SUM_W-1:0] v,
		input logic [CW-1:0] bound);
		logic [CW-1:0] r;
		if (v[SUM_W-1]) begin
			r = '0;
		end else if ((bound != '0) && (v >= $signed({2'b00, bound}))) begin
			r = bound - 1'b1;
		end else if (v > $signed({2'b00, {CW{1'b1}}})) begin
			r = {CW{1'b1}};
		end else begin
			r = v[CW-1:0];
		end
		return r;
	endfunction

	function automatic ps2mq_pkg::result_t none_result(input logic [CW-1:0] x,
		input logic [CW-1:0] y, input logic [2:0] b, input logic has);
		ps2mq_pkg::result_t r;
		r.ev.kind    = ps2mq_pkg::KIND_NONE;
		r.ev.button  = '0;
		r.ev.buttons = '0;
		r.ev.x       = x;
		r.ev.y       = y;
		r.cur_x      = x;
		r.cur_y      = y;
		r.cur_buttons = b;
		r.has_event  = has;
		return r;
	endfunction

	assign out_valid  = out_valid_q;
	assign res        = res_q;
	assign ring_empty = (head_q == tail_q);
	assign start      = (state_q == ST_IDLE) && cmd_valid && (!out_valid_q || !out_stall);
	assign cmd_pop    = start;
	assign rd_en      = start && (cmd.op == ps2mq_pkg::OP_TAKE) && !ring_empty;

	assign next_head = (head_q == PW'(ps2mq_pkg::QUEUE_DEPTH-1)) ? '0 : head_q + 1'b1;
	assign prev_head = (head_q == '0) ? PW'(ps2mq_pkg::QUEUE_DEPTH-1) : head_q - 1'b1;
	assign next_tail = (tail_q == PW'(ps2mq_pkg::QUEUE_DEPTH-1)) ? '0 : tail_q + 1'b1;
	assign full      = (next_head == tail_q);

	// Packet arithmetic for the third byte: nine-bit deltas, y inverted.
	assign dx       = $signed({first_q[4], second_q});
	assign dy       = $signed({first_q[5], cmd.data});
	assign sum_x    = $signed({2'b00, pos_x_q}) + {{(SUM_W-9){dx[8]}}, dx};
	assign sum_y    = $signed({2'b00, pos_y_q}) - {{(SUM_W-9){dy[8]}}, dy};
	assign new_x    = clamp_axis(sum_x, cfg.width);
	assign new_y    = clamp_axis(sum_y, cfg.height);
	assign delta_nz = (dx != '0) || (dy != '0);

	// Step 0 is the move event, steps 1 to 3 are the left, right and middle buttons.
	always_comb begin
		case (step_q)
			2'd1:    bit_sel = 3'b001;
			2'd2:    bit_sel = 3'b010;
			2'd3:    bit_sel = 3'b100;
			default: bit_sel = 3'b000;
		endcase
		push_req  = 1'b0;
		push_kind = ps2mq_pkg::KIND_MOVE;
		push_btn  = '0;
		if (step_q == '0) begin
			push_req = move_req_q;
		end else if (((btn_q & bit_sel) != '0) && ((prev_btn_q & bit_sel) == '0)) begin
			push_req  = 1'b1;
			push_kind = ps2mq_pkg::KIND_DOWN;
			push_btn  = bit_sel;
		end else if (((btn_q & bit_sel) == '0) && ((prev_btn_q & bit_sel) != '0)) begin
			push_req  = 1'b1;
			push_kind = ps2mq_pkg::KIND_UP;
			push_btn  = bit_sel;
		end
	end

	// A move that follows a queued move overwrites it in place.
	assign mem_we = (state_q == ST_PUSH) && push_req && !full;
	assign merge  = (push_kind == ps2mq_pkg::KIND_MOVE) && !ring_empty && last_move_q;
	assign mem_wa = merge ? prev_head : head_q;

	always_comb begin
		mem_wd.kind    = push_kind;
		mem_wd.button  = push_btn;
		mem_wd.buttons = btn_q;
		mem_wd.x       = pos_x_q;
		mem_wd.y       = pos_y_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_q <= mem[tail_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			byte_idx_q  <= '0;
			first_q     <= '0;
			second_q    <= '0;
			pos_x_q     <= ps2mq_pkg::POS_X_RST;
			pos_y_q     <= ps2mq_pkg::POS_Y_RST;
			btn_q       <= '0;
			prev_btn_q  <= '0;
			move_req_q  <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			last_move_q <= 1'b0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			// A command start decides the valid flag itself in every branch below.
			if (out_valid_q && !out_stall && !start) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (cmd.op)
							ps2mq_pkg::OP_TAKE: begin
								if (!ring_empty) begin
									tail_q      <= next_tail;
									out_valid_q <= 1'b0;
									state_q     <= ST_TAKE;
								end else begin
									res_q       <= none_result(pos_x_q, pos_y_q, btn_q, 1'b0);
									out_valid_q <= 1'b1;
								end
							end
							ps2mq_pkg::OP_BYTE: begin
								if (byte_idx_q == 2'd0) begin
									if ((cmd.data & ps2mq_pkg::SYNC_BIT) != '0) begin
										first_q    <= cmd.data;
										byte_idx_q <= 2'd1;
									end
									res_q       <= none_result(pos_x_q, pos_y_q, btn_q, !ring_empty);
									out_valid_q <= 1'b1;
								end else if (byte_idx_q == 2'd1) begin
									second_q    <= cmd.data;
									byte_idx_q  <= 2'd2;
									res_q       <= none_result(pos_x_q, pos_y_q, btn_q, !ring_empty);
									out_valid_q <= 1'b1;
								end else begin
									byte_idx_q <= 2'd0;
									if ((first_q & ps2mq_pkg::OVF_BITS) != '0) begin
										res_q       <= none_result(pos_x_q, pos_y_q, btn_q,
											!ring_empty);
										out_valid_q <= 1'b1;
									end else begin
										pos_x_q     <= new_x;
										pos_y_q     <= new_y;
										btn_q       <= first_q[2:0];
										prev_btn_q  <= btn_q;
										move_req_q  <= delta_nz;
										step_q      <= '0;
										out_valid_q <= 1'b0;
										state_q     <= ST_PUSH;
									end
								end
							end
							default: begin
								res_q       <= none_result(pos_x_q, pos_y_q, btn_q, !ring_empty);
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_TAKE: begin
					res_q.ev          <= rd_q;
					res_q.cur_x       <= pos_x_q;
					res_q.cur_y       <= pos_y_q;
					res_q.cur_buttons <= btn_q;
					res_q.has_event   <= !ring_empty;
					out_valid_q       <= 1'b1;
					state_q           <= ST_IDLE;
				end
				ST_PUSH: begin
					if (mem_we && !merge) begin
						head_q      <= next_head;
						last_move_q <= (push_kind == ps2mq_pkg::KIND_MOVE);
					end
					if (step_q == LAST_STEP) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DONE: begin
					res_q       <= none_result(pos_x_q, pos_y_q, btn_q, !ring_empty);
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Bound writes are to arrive only while the block is idle; this is not enforced here.
			if (cfg_wr.wr_width && (cfg_wr.value != '0) && (pos_x_q >= cfg_wr.value)) begin
				pos_x_q <= cfg_wr.value - 1'b1;
			end
			if (cfg_wr.wr_height && (cfg_wr.value != '0) && (pos_y_q >= cfg_wr.value)) begin
				pos_y_q <= cfg_wr.value - 1'b1;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> ($stable(res_q) && out_valid_q))
		else $error("pending result overwritten");

	a_x_in_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.width != '0) |-> (pos_x_q < cfg.width))
		else $error("cursor x beyond width bound");

	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !ring_empty)
		else $error("ring read while empty");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && !merge) |=> !ring_empty)
		else $error("ring empty after a push");

endmodule

`default_nettype wire
